### rtl/sms_pkg.sv
package sms_pkg;

  localparam int CAPACITY      = 256;
  localparam int ELEMENT_WIDTH = 32;

  localparam int ACTION_WIDTH  = 2;
  localparam int IN_ELEM_WIDTH = 32;
  localparam int STATUS_WIDTH  = 2;
  localparam int COUNT_WIDTH   = 9;

  // Code 3 is unused and behaves as a lookup.
  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  // Control part of a request as it walks down the cell chain.
  typedef struct packed {
    logic                    valid;
    logic [ACTION_WIDTH-1:0] action;
    logic                    found;
    logic                    placed;
  } ctl_t;

  typedef struct packed {
    logic                    found;
    logic [STATUS_WIDTH-1:0] status;
    logic [COUNT_WIDTH-1:0]  count;
  } rsp_t;

endpackage

### rtl/sms_ifs.sv
interface sms_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [sms_pkg::ACTION_WIDTH-1:0]         action;
  logic signed [sms_pkg::IN_ELEM_WIDTH-1:0] element;

  modport source (output valid, output action, output element, input ready);
  modport sink (input valid, input action, input element, output ready);
endinterface

interface sms_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [sms_pkg::STATUS_WIDTH-1:0] status;
  logic [sms_pkg::COUNT_WIDTH-1:0]  count;

  modport source (output valid, output found, output status, output count, input ready);
  modport sink (input valid, input found, input status, input count, output ready);
endinterface

### rtl/set_membership_store_top.sv
// A request walks the cell chain one cell per cycle; its response is formed as
// it leaves the last cell and is registered in the output register or skid stage.
// Only one request is in flight: the next is taken once the last has left the chain.
// A finished response may wait in the output register while the next request is
// taken; while a response waits in the skid stage, no request is taken.
// Reset (rst, synchronous): the set is emptied and the count reads zero.
module set_membership_store_top #(
  parameter int CAPACITY      = sms_pkg::CAPACITY,
  parameter int ELEMENT_WIDTH = sms_pkg::ELEMENT_WIDTH
) (
  input logic        clk,
  input logic        rst,
  sms_req_if.sink    req,
  sms_rsp_if.source  rsp
);

  localparam int HELD_WIDTH = $clog2(CAPACITY + 1);

  sms_pkg::ctl_t            ctl_link  [CAPACITY+1];
  logic [ELEMENT_WIDTH-1:0] elem_link [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_busy;

  logic signed [63:0]       elem_ext;
  logic                     accept;
  logic                     busy;
  logic [HELD_WIDTH-1:0]    held;
  logic [HELD_WIDTH-1:0]    held_next;
  sms_pkg::ctl_t            res_ctl;
  sms_pkg::rsp_t            res;
  sms_pkg::rsp_t            out_data;
  sms_pkg::rsp_t            skid_data;
  logic                     out_valid;
  logic                     skid_valid;
  logic                     out_take;

  assign accept   = req.valid && req.ready;
  assign req.ready = !rst && !busy && !skid_valid;

  assign elem_ext     = 64'(req.element);
  assign elem_link[0] = elem_ext[ELEMENT_WIDTH-1:0];

  always_comb begin
    ctl_link[0].valid  = accept;
    ctl_link[0].action = req.action;
    ctl_link[0].found  = 1'b0;
    ctl_link[0].placed = 1'b0;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k < CAPACITY - 1) begin : g_mid
      sms_cell #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl_in    (ctl_link[k]),
        .elem_in   (elem_link[k]),
        .nbr_entry (cell_entry[k+1]),
        .nbr_valid (cell_valid[k+1]),
        .ctl_out   (ctl_link[k+1]),
        .elem_out  (elem_link[k+1]),
        .entry     (cell_entry[k]),
        .valid     (cell_valid[k]),
        .busy      (cell_busy[k])
      );
    end else begin : g_last
      sms_cell #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl_in    (ctl_link[k]),
        .elem_in   (elem_link[k]),
        .nbr_entry ('0),
        .nbr_valid (1'b0),
        .ctl_out   (ctl_link[k+1]),
        .elem_out  (),
        .entry     (cell_entry[k]),
        .valid     (cell_valid[k]),
        .busy      (cell_busy[k])
      );
    end
  end

  assign res_ctl = ctl_link[CAPACITY];

  // Response formation as the request leaves the last cell.
  always_comb begin
    held_next  = held;
    res.found  = res_ctl.found;
    res.status = sms_pkg::STATUS_DONE;
    unique case (res_ctl.action)
      sms_pkg::ACT_INSERT: begin
        priority if (res_ctl.found) begin
          res.status = sms_pkg::STATUS_REJECT;
        end else if (res_ctl.placed) begin
          held_next = held + HELD_WIDTH'(1);
        end else begin
          res.status = sms_pkg::STATUS_FULL;
        end
      end
      sms_pkg::ACT_REMOVE: begin
        if (res_ctl.found) begin
          held_next = held - HELD_WIDTH'(1);
        end else begin
          res.status = sms_pkg::STATUS_REJECT;
        end
      end
      default: begin
        res.status = sms_pkg::STATUS_DONE;
      end
    endcase
    res.count = sms_pkg::COUNT_WIDTH'({{sms_pkg::COUNT_WIDTH{1'b0}}, held_next});
  end

  assign out_take = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      held       <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (res_ctl.valid) begin
        busy <= 1'b0;
      end
      if (res_ctl.valid) begin
        held <= held_next;
      end
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= res_ctl.valid;
        end else begin
          out_valid <= res_ctl.valid;
        end
      end else if (res_ctl.valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (res_ctl.valid) begin
      skid_data <= res;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.found  = out_data.found;
  assign rsp.status = out_data.status;
  assign rsp.count  = out_data.count;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_busy))
    else $error("more than one request in the cell chain");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (held == HELD_WIDTH'($countones(cell_valid))))
    else $error("held count disagrees with occupied cells");

  a_result_when_busy: assert property (@(posedge clk) disable iff (rst)
    res_ctl.valid |-> busy)
    else $error("response left the chain with no request in flight");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_low_cells_packed: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ((cell_valid & (cell_valid + CAPACITY'(1))) == '0))
    else $error("held entries are not packed into the low cells");
`endif

endmodule

### rtl/sms_cell.sv
module sms_cell #(
  parameter int ELEMENT_WIDTH = sms_pkg::ELEMENT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sms_pkg::ctl_t            ctl_in,
  input  logic [ELEMENT_WIDTH-1:0] elem_in,
  input  logic [ELEMENT_WIDTH-1:0] nbr_entry,
  input  logic                     nbr_valid,
  output sms_pkg::ctl_t            ctl_out,
  output logic [ELEMENT_WIDTH-1:0] elem_out,
  output logic [ELEMENT_WIDTH-1:0] entry,
  output logic                     valid,
  output logic                     busy
);

  sms_pkg::ctl_t            ctl;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic                     hit;
  logic                     take;
  logic                     shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    elem <= elem_in;
  end

  assign hit = valid && (entry == elem);

  // Held entries fill the low cells, so the first empty cell an absent insert
  // reaches is the append slot.
  assign take = ctl.valid && (ctl.action == sms_pkg::ACT_INSERT) &&
                !ctl.found && !ctl.placed && !valid;

  // A remove pulls the right neighbor in from the match onward; the neighbor
  // has not yet seen this request, so it still holds its old contents.
  assign shift = ctl.valid && (ctl.action == sms_pkg::ACT_REMOVE) && (ctl.found || hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= nbr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry <= elem;
    end else if (shift) begin
      entry <= nbr_entry;
    end
  end

  always_comb begin
    ctl_out        = ctl;
    ctl_out.found  = ctl.found || hit;
    ctl_out.placed = ctl.placed || take;
  end

  assign elem_out = elem;
  assign busy     = ctl.valid;

endmodule

### tb/set_membership_store_top_tb.sv
`timescale 1ns / 100ps

module set_membership_store_top_tb;

  localparam int EW          = sms_pkg::ELEMENT_WIDTH;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = sms_pkg::CAPACITY + 16;

  // code 3 is unused and must act as a lookup
  localparam logic [sms_pkg::ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;

  sms_req_if req_ch ();
  sms_rsp_if rsp_ch ();

  set_membership_store_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // held elements in insertion order, slot 0 first
  logic [EW-1:0]  set_contents[$];
  sms_pkg::rsp_t  pending_rsp[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  function automatic int slot_of(logic [EW-1:0] v);
    foreach (set_contents[i]) begin
      if (set_contents[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic sms_pkg::rsp_t apply_request(
      logic [sms_pkg::ACTION_WIDTH-1:0] act,
      logic signed [sms_pkg::IN_ELEM_WIDTH-1:0] elem);
    sms_pkg::rsp_t      r;
    logic signed [63:0] wide;
    logic [EW-1:0]      v;
    int                 slot;
    wide = elem;
    v = wide[EW-1:0];
    slot = slot_of(v);
    r.found = (slot >= 0);
    r.status = sms_pkg::STATUS_DONE;
    case (act)
      sms_pkg::ACT_INSERT: begin
        // duplicate check wins over the full check
        if (r.found) r.status = sms_pkg::STATUS_REJECT;
        else if (set_contents.size() >= sms_pkg::CAPACITY) r.status = sms_pkg::STATUS_FULL;
        else set_contents.push_back(v);
      end
      sms_pkg::ACT_REMOVE: begin
        if (!r.found) r.status = sms_pkg::STATUS_REJECT;
        else set_contents.delete(slot);
      end
      default: ;
    endcase
    r.count = sms_pkg::COUNT_WIDTH'(set_contents.size());
    return r;
  endfunction

  function automatic logic signed [sms_pkg::IN_ELEM_WIDTH-1:0] pick_element();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45 && set_contents.size() != 0)
      return set_contents[$urandom_range(set_contents.size() - 1)];
    else if (roll < 70)
      return $signed(sms_pkg::IN_ELEM_WIDTH'($urandom_range(31))) - 16;
    else if (roll < 95)
      return $urandom;
    case ($urandom_range(3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic signed [sms_pkg::IN_ELEM_WIDTH-1:0] fresh_element();
    logic signed [sms_pkg::IN_ELEM_WIDTH-1:0] e;
    do e = $urandom; while (slot_of(e[EW-1:0]) >= 0);
    return e;
  endfunction

  task automatic send_request(input logic [sms_pkg::ACTION_WIDTH-1:0] act,
                              input logic signed [sms_pkg::IN_ELEM_WIDTH-1:0] elem);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.element <= elem;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_rsp.push_back(apply_request(act, elem));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(sms_pkg::ACT_LOOKUP, 32'sh0);
    send_request(sms_pkg::ACT_REMOVE, 32'sh0);
    send_request(sms_pkg::ACT_INSERT, 32'sh8000_0000);
    send_request(sms_pkg::ACT_INSERT, 32'sh7fff_ffff);
    send_request(sms_pkg::ACT_INSERT, 32'sh0);
    send_request(sms_pkg::ACT_INSERT, -32'sd1);
    send_request(sms_pkg::ACT_INSERT, 32'sh0);
    send_request(sms_pkg::ACT_LOOKUP, 32'sh7fff_ffff);
    send_request(ACT_UNUSED, -32'sd1);
    send_request(ACT_UNUSED, 32'sd5);
    // middle remove: later entries must shift down
    send_request(sms_pkg::ACT_REMOVE, 32'sh7fff_ffff);
    send_request(sms_pkg::ACT_LOOKUP, 32'sh0);
    send_request(sms_pkg::ACT_LOOKUP, 32'sh8000_0000);
    send_request(sms_pkg::ACT_LOOKUP, -32'sd1);
    send_request(sms_pkg::ACT_REMOVE, -32'sd1);
    send_request(sms_pkg::ACT_REMOVE, 32'sh8000_0000);
    send_request(sms_pkg::ACT_INSERT, 32'sh7fff_ffff);
    send_request(sms_pkg::ACT_INSERT, 32'sd1);
    send_request(sms_pkg::ACT_LOOKUP, 32'sd1);
    hold_until_drained();
    send_request(sms_pkg::ACT_REMOVE, 32'sh0);
    send_request(sms_pkg::ACT_REMOVE, 32'sh7fff_ffff);
    send_request(sms_pkg::ACT_REMOVE, 32'sd1);
    send_request(sms_pkg::ACT_REMOVE, 32'sd1);
  endtask

  task automatic test_fill_to_capacity();
    while (set_contents.size() < sms_pkg::CAPACITY)
      send_request(sms_pkg::ACT_INSERT, fresh_element());
    send_request(sms_pkg::ACT_INSERT, fresh_element());
    send_request(sms_pkg::ACT_INSERT, set_contents[sms_pkg::CAPACITY / 2]);
    send_request(sms_pkg::ACT_LOOKUP, set_contents[sms_pkg::CAPACITY - 1]);
    send_request(sms_pkg::ACT_REMOVE, set_contents[sms_pkg::CAPACITY / 3]);
    send_request(sms_pkg::ACT_INSERT, fresh_element());
    send_request(sms_pkg::ACT_INSERT, fresh_element());
    send_request(sms_pkg::ACT_REMOVE, set_contents[0]);
    send_request(sms_pkg::ACT_REMOVE, set_contents[set_contents.size() - 1]);
    send_request(sms_pkg::ACT_LOOKUP, set_contents[0]);
  endtask

  task automatic test_random_mix(input int n, input int insert_pct, input int remove_pct);
    int                               roll;
    logic [sms_pkg::ACTION_WIDTH-1:0] act;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < insert_pct) act = sms_pkg::ACT_INSERT;
      else if (roll < insert_pct + remove_pct) act = sms_pkg::ACT_REMOVE;
      else if (roll < 95) act = sms_pkg::ACT_LOOKUP;
      else act = ACT_UNUSED;
      send_request(act, pick_element());
    end
  endtask

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    sms_pkg::rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request pending");
        mismatch_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_ch.found !== exp_rsp.found) begin
          $error("found: expected %0d, got %0d", exp_rsp.found, rsp_ch.found);
          mismatch_count++;
        end
        if (rsp_ch.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.count !== exp_rsp.count) begin
          $error("count: expected %0d, got %0d", exp_rsp.count, rsp_ch.count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = sms_pkg::ACT_LOOKUP;
    req_ch.element = '0;
    rsp_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 28;
    rcv_idle_pct = 70;
    test_directed();
    test_random_mix(250, 45, 25);
    hold_until_drained();

    snd_idle_pct = 70;
    rcv_idle_pct = 28;
    test_fill_to_capacity();
    test_random_mix(250, 20, 50);
    hold_until_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_mix(150, 35, 35);
    hold_until_drained();
    test_random_mix(150, 35, 35);
    hold_until_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/sms_pkg.sv
rtl/sms_ifs.sv
rtl/sms_cell.sv
rtl/set_membership_store_top.sv
tb/set_membership_store_top_tb.sv
